[hdl/kmse_pkg.sv]
// ----------------------------------------------------------------------------
// kmse_pkg
// Shared constants, types and result codes for the key matrix scanner.
// ----------------------------------------------------------------------------
package kmse_pkg;

    localparam int ROWS    = 6;
    localparam int COLS    = 6;
    localparam int NKEYS   = ROWS * COLS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CNT_W   = $clog2(NKEYS + 1);

    // fixed field widths of the ports
    localparam int LEVEL_W = 6;
    localparam int MASK_W  = 36;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 6;
    localparam int FRAME_W = 36;
    localparam int FCNT_W  = 6;

    // keys 24, 25, 30 and 31 left out of the frame
    localparam logic [MASK_W-1:0] MASK_RESET = 36'h0_C300_0000;

    typedef logic [NKEYS-1:0] t_keys;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_FRAME   = 2'd2
    } t_kind;

    typedef struct packed {
        logic chg;
        logic press;
    } t_lane;

    typedef struct packed {
        logic [COLS-1:0]  chg;
        logic [COLS-1:0]  press;
        logic [ROW_W-1:0] row;
        logic             frame;
        t_keys            snap;
    } t_job;

endpackage

[hdl/key_matrix_scan_events_core.sv]
// ----------------------------------------------------------------------------
// key_matrix_scan_events_core
// Key matrix scanner: press and release events per row and a packed frame.
// ----------------------------------------------------------------------------
// Each request carries the active-low column levels of the next row in turn.
// All columns of the row are compared with the stored key state at once, one
// lane per column. The merge stage then sends one event per cycle in column
// order while the output is not stalled; after the last row it packs the frame
// one row per cycle, starting with the first row, and sends the frame after the
// events of that row. A request with no result is not passed to the merge
// stage. The next request is taken in the cycle the final result moves to the
// output register. The mask register may be written only while no request is
// being worked on.
module key_matrix_scan_events_core import kmse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MASK_W-1:0]   i_cfg_unused_key_mask,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [LEVEL_W-1:0]  i_column_levels,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [IDX_W-1:0]    o_key_index,
    output logic [FRAME_W-1:0]  o_frame_bits,
    output logic [FCNT_W-1:0]   o_frame_count,
    output logic                o_last
);

    logic [MASK_W-1:0] r_mask;
    t_keys             r_pressed;
    logic [ROW_W-1:0]  r_row;

    logic [COLS-1:0]   closed;
    logic [COLS-1:0]   was;
    t_lane             flag [COLS];
    t_keys             n_pressed;
    t_job              job;
    logic              load_ok;
    logic              accept;
    logic              last_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = load_ok;
    assign accept      = i_in_valid && load_ok;
    assign last_row    = (r_row == ROW_W'(ROWS - 1));
    assign was         = r_pressed[r_row * COLS +: COLS];

    for (genvar c = 0; c < COLS; c++) begin : g_lane
        // columns without an input line read as open
        if (c < LEVEL_W) begin : g_in
            assign closed[c] = ~i_column_levels[c];
        end else begin : g_open
            assign closed[c] = 1'b0;
        end

        kmse_lane u_lane (
            .i_closed (closed[c]),
            .i_was    (was[c]),
            .o_flag   (flag[c])
        );

        assign job.chg[c]   = flag[c].chg;
        assign job.press[c] = flag[c].press;
    end

    always_comb begin
        n_pressed = r_pressed;
        n_pressed[r_row * COLS +: COLS] = closed;
    end

    assign job.row   = r_row;
    assign job.frame = last_row;
    assign job.snap  = n_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= MASK_RESET;
            r_pressed <= '0;
            r_row     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_unused_key_mask;
            end
            if (accept) begin
                r_pressed <= n_pressed;
                r_row     <= last_row ? '0 : r_row + 1'b1;
            end
        end
    end

    kmse_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept && ((|job.chg) || last_row)),
        .i_job         (job),
        .i_mask        (r_mask),
        .o_load_ok     (load_ok),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_key_index   (o_key_index),
        .o_frame_bits  (o_frame_bits),
        .o_frame_count (o_frame_count),
        .o_last        (o_last)
    );

endmodule

[hdl/kmse_lane.sv]
// ----------------------------------------------------------------------------
// kmse_lane
// One column of the current row: finds a press or a release of its key.
// ----------------------------------------------------------------------------
module kmse_lane import kmse_pkg::*; (
    input  logic  i_closed,
    input  logic  i_was,
    output t_lane o_flag
);

    assign o_flag.chg   = i_closed ^ i_was;
    assign o_flag.press = i_closed & ~i_was;

endmodule

[hdl/kmse_merge.sv]
// ----------------------------------------------------------------------------
// kmse_merge
// Merges the lane results into events in column order, packs the state frame
// one row per cycle and holds the output register.
// ----------------------------------------------------------------------------
module kmse_merge import kmse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_job                i_job,
    input  logic [MASK_W-1:0]   i_mask,
    output logic                o_load_ok,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [IDX_W-1:0]    o_key_index,
    output logic [FRAME_W-1:0]  o_frame_bits,
    output logic [FCNT_W-1:0]   o_frame_count,
    output logic                o_last
);

    logic               r_busy;
    t_job               r_job;
    logic [ROW_W-1:0]   r_pk_row;
    logic               r_pk_done;
    logic [FRAME_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [IDX_W-1:0]   r_idx;
    logic [FRAME_W-1:0] r_bits;
    logic [FCNT_W-1:0]  r_fcnt;
    logic               r_last;

    logic               push_ok;
    logic [COL_W-1:0]   col;
    logic [COLS-1:0]    rest;
    logic               emit_evt;
    logic               emit_frm;
    logic               done;
    logic               load;
    t_keys              mask_ext;
    logic [COLS-1:0]    snap_row;
    logic [COLS-1:0]    mask_row;
    logic [FRAME_W-1:0] n_acc;
    logic [CNT_W-1:0]   n_cnt;

    // lowest changed column goes first
    always_comb begin
        logic found;
        found = 1'b0;
        col   = '0;
        for (int c = 0; c < COLS; c++) begin
            if (!found && r_job.chg[c]) begin
                found = 1'b1;
                col   = COL_W'(c);
            end
        end
    end

    assign rest      = r_job.chg & ~(COLS'(1) << col);
    assign push_ok   = !r_out_valid || i_out_ready;
    assign emit_evt  = r_busy && push_ok && (|r_job.chg);
    assign emit_frm  = r_busy && push_ok && !(|r_job.chg) && r_job.frame && r_pk_done;
    assign done      = (emit_evt && (rest == '0) && !r_job.frame) || emit_frm;
    assign o_load_ok = !r_busy || done;
    assign load      = i_load && o_load_ok;

    // keys beyond the mask register are never left out
    assign mask_ext = t_keys'(i_mask);
    assign snap_row = r_job.snap[r_pk_row * COLS +: COLS];
    assign mask_row = mask_ext[r_pk_row * COLS +: COLS];

    // compact one row of kept keys onto the running frame
    always_comb begin
        logic [COL_W:0]   l;
        logic [CNT_W:0]   pos;
        l     = '0;
        pos   = '0;
        n_acc = r_acc;
        for (int c = 0; c < COLS; c++) begin
            if (!mask_row[c]) begin
                pos = (CNT_W + 1)'(r_cnt) + (CNT_W + 1)'(l);
                if (snap_row[c]) begin
                    n_acc = n_acc | (FRAME_W'(1) << pos);
                end
                l = l + 1'b1;
            end
        end
        n_cnt = r_cnt + CNT_W'(l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pk_done   <= 1'b0;
            r_pk_row    <= '0;
        end else begin
            if (load) begin
                r_busy    <= 1'b1;
                r_job     <= i_job;
                r_pk_row  <= '0;
                r_pk_done <= 1'b0;
                r_acc     <= '0;
                r_cnt     <= '0;
            end else begin
                if (emit_evt) begin
                    r_job.chg <= rest;
                end
                if (done) begin
                    r_busy <= 1'b0;
                end
                if (r_busy && !r_pk_done) begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                    if (r_pk_row == ROW_W'(ROWS - 1)) begin
                        r_pk_done <= 1'b1;
                    end else begin
                        r_pk_row <= r_pk_row + 1'b1;
                    end
                end
            end

            if (emit_evt) begin
                r_out_valid <= 1'b1;
                r_kind      <= r_job.press[col] ? KIND_PRESS : KIND_RELEASE;
                r_idx       <= IDX_W'(r_job.row * COLS + col);
                r_bits      <= '0;
                r_fcnt      <= '0;
                r_last      <= (rest == '0) && !r_job.frame;
            end else if (emit_frm) begin
                r_out_valid <= 1'b1;
                r_kind      <= KIND_FRAME;
                r_idx       <= '0;
                r_bits      <= r_acc;
                r_fcnt      <= FCNT_W'(r_cnt);
                r_last      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_key_index   = r_idx;
    assign o_frame_bits  = r_bits;
    assign o_frame_count = r_fcnt;
    assign o_last        = r_last;

endmodule
